// ----- rtl/lts_pkg.sv -----
// Shared types and codes for the lottery ticket scheduler.
`timescale 1ns / 1ps
`default_nettype none
package lts_pkg;
  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_RETIRE = 2'd1,
    KIND_DRAW   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FREE_EMPTY = 2'd1,
    ST_NONE_HELD  = 2'd2,
    ST_NO_OWNER   = 2'd3
  } status_t;
endpackage
`default_nettype wire

// ----- rtl/lts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/lottery_ticket_scheduler.sv -----
// Top level of the lottery ticket scheduler: sequencer over the list memories.
//
// One operation is worked on at a time. Each memory has one read port with
// registered read data, so every list walk spends an address step and then a
// data step on each entry. The modulo of the random value runs as a restoring
// divider, one quotient bit per cycle. Allocate then compacts the free list;
// draw then searches the owner lists, which together hold at most NUM_TICKETS
// tickets; retire removes each of the process's k tickets from the held list
// by a search and compaction pass. After reset a clearing pass writes the
// free list with ticket i at entry i, during which no transfer is accepted.
// The result sits in an output register, so the next item is accepted while
// it waits; a finished item holds in the output step until that register is
// free.
`timescale 1ns / 1ps
`default_nettype none
module lottery_ticket_scheduler #(
  parameter int NUM_TICKETS   = 32,
  parameter int NUM_PROCESSES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // kind[1:0], process_id[4:2], random_value[20:5]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // ticket[4:0], winner[7:5], status[9:8]
);
  import lts_pkg::*;

  localparam int TW = (NUM_TICKETS > 2) ? $clog2(NUM_TICKETS) : 1;
  localparam int CW = $clog2(NUM_TICKETS + 1);
  localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int OD = NUM_PROCESSES * NUM_TICKETS;
  localparam int OW = $clog2(OD);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DIV, S_A_RD, S_A_SHR, S_A_SHW, S_A_FIN,
    S_R_RD, S_R_WT, S_R_HRD, S_R_HCMP, S_R_SHR, S_R_SHW, S_R_NEXT,
    S_D_RD, S_D_WT, S_D_ORD, S_D_OCMP, S_OUT
  } state_t;

  state_t state;
  logic [1:0]  kind;
  logic [2:0]  pid_in;
  logic [PW-1:0] pid;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [4:0]  bitc;
  logic [CW-1:0] divisor;
  logic [CW-1:0] free_count, held_count;
  logic [CW-1:0] owned_count [NUM_PROCESSES];
  logic [CW-1:0] idx, lim, k;
  logic [PW-1:0] p;
  logic [TW-1:0] tk;
  logic [4:0]  out_ticket;
  logic [2:0]  out_winner;
  logic [1:0]  out_status;

  // Memory ports.
  logic          f_we, h_we, o_we;
  logic [TW-1:0] f_wa, f_ra, h_wa, h_ra;
  logic [TW-1:0] f_wd, h_wd, o_wd, f_rd, h_rd, o_rd;
  logic [OW-1:0] o_wa, o_ra;

  lts_ram #(.WIDTH(TW), .DEPTH(NUM_TICKETS)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  lts_ram #(.WIDTH(TW), .DEPTH(NUM_TICKETS)) u_held (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  lts_ram #(.WIDTH(TW), .DEPTH(OD)) u_owned (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  logic [16:0] trial;
  assign trial = {rem, quo[15]} - {{(17-CW){1'b0}}, divisor};

  function automatic logic [OW-1:0] oaddr(input logic [PW-1:0] pp, input logic [CW-1:0] kk);
    logic [OW:0] a;
    a = (OW+1)'(pp) * (OW+1)'(NUM_TICKETS) + (OW+1)'(kk);
    return a[OW-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    f_we = 1'b0; f_wa = idx[TW-1:0]; f_wd = f_rd; f_ra = idx[TW-1:0];
    h_we = 1'b0; h_wa = idx[TW-1:0]; h_wd = h_rd; h_ra = idx[TW-1:0];
    o_we = 1'b0; o_wa = oaddr(pid, owned_count[pid]); o_wd = tk; o_ra = oaddr(pid, k);
    case (state)
      S_INIT: begin
        f_we = 1'b1; f_wd = idx[TW-1:0];
      end
      S_A_RD: f_ra = rem[TW-1:0];
      S_A_SHR: f_ra = TW'(idx + 1'b1);
      S_A_SHW: f_we = 1'b1;
      S_A_FIN: begin
        f_wa = idx[TW-1:0];
        h_we = held_count < CW'(NUM_TICKETS);
        h_wa = held_count[TW-1:0]; h_wd = tk;
        o_we = owned_count[pid] < CW'(NUM_TICKETS);
      end
      S_R_RD: o_ra = oaddr(pid, k);
      S_R_HRD: h_ra = idx[TW-1:0];
      S_R_SHR: h_ra = TW'(idx + 1'b1);
      S_R_SHW: h_we = 1'b1;
      S_R_WT: begin
        f_we = free_count < CW'(NUM_TICKETS);
        f_wa = free_count[TW-1:0]; f_wd = o_rd;
      end
      S_D_RD: h_ra = rem[TW-1:0];
      S_D_ORD: o_ra = oaddr(p, k);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      free_count <= CW'(NUM_TICKETS);
      held_count <= '0;
      for (int i = 0; i < NUM_PROCESSES; i++) owned_count[i] <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_INIT: begin
          idx <= idx + 1'b1;
          if (idx == CW'(NUM_TICKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= s_axis_tdata[1:0];
            pid_in <= s_axis_tdata[4:2];
            pid <= PW'(s_axis_tdata[4:2]);
            quo <= s_axis_tdata[20:5];
            rem <= '0;
            bitc <= 5'd16;
            k <= '0;
            p <= '0;
            out_ticket <= '0; out_winner <= '0; out_status <= ST_OK;
            state <= S_OUT;
            case (kind_t'(s_axis_tdata[1:0]))
              KIND_ALLOC: begin
                if ({29'd0, s_axis_tdata[4:2]} >= NUM_PROCESSES) state <= S_OUT;
                else if (free_count == '0) begin
                  out_status <= ST_FREE_EMPTY;
                end else begin
                  divisor <= free_count; state <= S_DIV;
                end
              end
              KIND_RETIRE: begin
                if ({29'd0, s_axis_tdata[4:2]} < NUM_PROCESSES) state <= S_R_NEXT;
              end
              KIND_DRAW: begin
                if (held_count == '0) out_status <= ST_NONE_HELD;
                else begin
                  divisor <= held_count; state <= S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          quo <= {quo[14:0], 1'b0};
          if (!trial[16]) rem <= trial[15:0];
          else rem <= {rem[14:0], quo[15]};
          bitc <= bitc - 1'b1;
          if (bitc == 5'd1) state <= (kind == KIND_ALLOC) ? S_A_RD : S_D_RD;
        end
        S_A_RD: begin
          idx <= CW'(rem);
          state <= S_A_SHR;
        end
        S_A_SHR: begin
          if (idx == CW'(rem)) tk <= f_rd;
          if (idx + 1'b1 < free_count) state <= S_A_SHW;
          else state <= S_A_FIN;
        end
        S_A_SHW: begin
          idx <= idx + 1'b1;
          state <= S_A_SHR;
        end
        S_A_FIN: begin
          free_count <= free_count - 1'b1;
          if (held_count < CW'(NUM_TICKETS)) held_count <= held_count + 1'b1;
          if (owned_count[pid] < CW'(NUM_TICKETS))
            owned_count[pid] <= owned_count[pid] + 1'b1;
          out_ticket <= 5'(tk);
          state <= S_OUT;
        end
        S_R_NEXT: begin
          if (k < owned_count[pid]) state <= S_R_RD;
          else begin
            owned_count[pid] <= '0;
            state <= S_OUT;
          end
        end
        S_R_RD: state <= S_R_WT;
        S_R_WT: begin
          tk <= o_rd;
          if (free_count < CW'(NUM_TICKETS)) free_count <= free_count + 1'b1;
          idx <= '0;
          state <= S_R_HRD;
        end
        S_R_HRD: begin
          if (idx < held_count) state <= S_R_HCMP;
          else begin
            k <= k + 1'b1; state <= S_R_NEXT;
          end
        end
        S_R_HCMP: begin
          if (h_rd == tk) state <= S_R_SHR;
          else begin
            idx <= idx + 1'b1; state <= S_R_HRD;
          end
        end
        S_R_SHR: begin
          if (idx + 1'b1 < held_count) state <= S_R_SHW;
          else begin
            held_count <= held_count - 1'b1;
            k <= k + 1'b1;
            state <= S_R_NEXT;
          end
        end
        S_R_SHW: begin
          idx <= idx + 1'b1;
          state <= S_R_SHR;
        end
        S_D_RD: state <= S_D_WT;
        S_D_WT: begin
          tk <= h_rd;
          out_ticket <= 5'(h_rd);
          state <= S_D_ORD;
        end
        S_D_ORD: begin
          if (k < owned_count[p]) state <= S_D_OCMP;
          else if (p == PW'(NUM_PROCESSES - 1)) begin
            out_status <= ST_NO_OWNER; state <= S_OUT;
          end else begin
            p <= p + 1'b1; k <= '0;
          end
        end
        S_D_OCMP: begin
          if (o_rd == tk) begin
            out_winner <= 3'(p); state <= S_OUT;
          end else begin
            k <= k + 1'b1; state <= S_D_ORD;
          end
        end
        S_OUT: begin
          // The result moves on only once the previous one has been taken.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata <= {6'd0, out_status, out_winner, out_ticket};
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Whenever the scheduler is idle, the pools hold no more tickets together than exist.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ({1'b0, free_count} + {1'b0, held_count} <= (CW+1)'(NUM_TICKETS)))
    else $error("ticket pools exceed pool size");
  // A result is raised only from the output step.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_OUT))
    else $error("result raised outside output step");
  // A finished allocate always leaves one ticket fewer in the free pool.
  a_alloc_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_FIN) |=> (free_count == $past(free_count) - 1'b1))
    else $error("free count not decremented");
  // No input transfer while the clearing pass runs.
  a_init_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !s_axis_tready)
    else $error("ready during clearing pass");

  logic unused;
  assign unused = ^{pid_in, idx[CW-1], quo[0]};
endmodule
`default_nettype wire
